### sv/scc_pkg.sv
`default_nettype none
package scc_pkg;

	// Field widths fixed by the item formats.
	localparam int VW = 6;
	localparam int TW = 8;
	localparam int CW = 7;

	// Default graph size and the reset value of the vertex count register.
	localparam int MAX_VERTICES_DEF = 64;
	localparam logic [CW-1:0] VCOUNT_RESET = 7'd64;

	// Request command codes.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [VW-1:0] src_vertex;
		logic [VW-1:0] dst_vertex;
		logic signed [15:0] edge_weight;
	} req_item_t;

	typedef struct packed {
		logic [VW-1:0] vertex;
		logic [VW-1:0] root;
		logic [TW-1:0] finish_time;
		logic last;
	} res_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_P1_SCAN,
		ST_P1_FETCH,
		ST_P1_STEP,
		ST_P1_POP,
		ST_P2_ORD,
		ST_P2_SEL,
		ST_P2_EMIT,
		ST_P2_FETCH,
		ST_P2_STEP,
		ST_P2_POP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ADD_RD,
		OP_ADD_WR,
		OP_RUN_INIT,
		OP_P1_SCAN,
		OP_FETCH,
		OP_STEP,
		OP_POP,
		OP_ORD_RD,
		OP_SEL,
		OP_EMIT
	} op_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		op_t op;
		logic second;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic n_zero;
		logic add_ok;
		logic scan_done;
		logic scan_hit;
		logic cand_any;
		logic stack_empty;
		logic sel_visited;
		logic out_free;
		logic last_emit;
	} stat_t;

endpackage
`default_nettype wire

### sv/scc_ram.sv
`default_nettype none
module scc_ram #(
	parameter int W = 8,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [W-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/scc_ctrl.sv
`default_nettype none
module scc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic [1:0] req_cmd,
	input wire scc_pkg::stat_t stat,
	output logic req_stall,
	output scc_pkg::ctrl_t ctrl
);

	scc_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			scc_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_cmd == scc_pkg::CMD_ADD && stat.add_ok) begin
						state_d = scc_pkg::ST_ADD_WR;
					end else if (req_cmd == scc_pkg::CMD_RUN && !stat.n_zero) begin
						state_d = scc_pkg::ST_P1_SCAN;
					end
				end
			end
			scc_pkg::ST_ADD_WR: state_d = scc_pkg::ST_IDLE;
			scc_pkg::ST_P1_SCAN: begin
				if (stat.scan_done) begin
					state_d = scc_pkg::ST_P2_ORD;
				end else if (stat.scan_hit) begin
					state_d = scc_pkg::ST_P1_FETCH;
				end
			end
			scc_pkg::ST_P1_FETCH: state_d = scc_pkg::ST_P1_STEP;
			scc_pkg::ST_P1_STEP: begin
				if (stat.cand_any) begin
					state_d = scc_pkg::ST_P1_FETCH;
				end else if (stat.stack_empty) begin
					state_d = scc_pkg::ST_P1_SCAN;
				end else begin
					state_d = scc_pkg::ST_P1_POP;
				end
			end
			scc_pkg::ST_P1_POP: state_d = scc_pkg::ST_P1_FETCH;
			scc_pkg::ST_P2_ORD: state_d = scc_pkg::ST_P2_SEL;
			scc_pkg::ST_P2_SEL: begin
				if (stat.sel_visited) begin
					state_d = scc_pkg::ST_P2_ORD;
				end else begin
					state_d = scc_pkg::ST_P2_EMIT;
				end
			end
			scc_pkg::ST_P2_EMIT: begin
				if (stat.out_free) begin
					state_d = stat.last_emit ? scc_pkg::ST_IDLE : scc_pkg::ST_P2_FETCH;
				end
			end
			scc_pkg::ST_P2_FETCH: state_d = scc_pkg::ST_P2_STEP;
			scc_pkg::ST_P2_STEP: begin
				if (stat.cand_any) begin
					state_d = scc_pkg::ST_P2_EMIT;
				end else if (stat.stack_empty) begin
					state_d = scc_pkg::ST_P2_ORD;
				end else begin
					state_d = scc_pkg::ST_P2_POP;
				end
			end
			scc_pkg::ST_P2_POP: state_d = scc_pkg::ST_P2_FETCH;
			default: state_d = scc_pkg::ST_IDLE;
		endcase
	end

	// Outputs: the datapath command for this cycle.
	always_comb begin
		ctrl.op = scc_pkg::OP_NONE;
		ctrl.second = 1'b0;
		req_stall = 1'b1;
		case (state_q)
			scc_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					case (req_cmd)
						scc_pkg::CMD_CLEAR: ctrl.op = scc_pkg::OP_CLEAR;
						scc_pkg::CMD_ADD:
							ctrl.op = stat.add_ok ? scc_pkg::OP_ADD_RD : scc_pkg::OP_NONE;
						scc_pkg::CMD_RUN:
							ctrl.op = stat.n_zero ? scc_pkg::OP_NONE : scc_pkg::OP_RUN_INIT;
						default: ctrl.op = scc_pkg::OP_NONE;
					endcase
				end
			end
			scc_pkg::ST_ADD_WR: ctrl.op = scc_pkg::OP_ADD_WR;
			scc_pkg::ST_P1_SCAN: ctrl.op = scc_pkg::OP_P1_SCAN;
			scc_pkg::ST_P1_FETCH: ctrl.op = scc_pkg::OP_FETCH;
			scc_pkg::ST_P1_STEP: ctrl.op = scc_pkg::OP_STEP;
			scc_pkg::ST_P1_POP: ctrl.op = scc_pkg::OP_POP;
			scc_pkg::ST_P2_ORD: begin
				ctrl.op = scc_pkg::OP_ORD_RD;
				ctrl.second = 1'b1;
			end
			scc_pkg::ST_P2_SEL: begin
				ctrl.op = scc_pkg::OP_SEL;
				ctrl.second = 1'b1;
			end
			scc_pkg::ST_P2_EMIT: begin
				ctrl.op = stat.out_free ? scc_pkg::OP_EMIT : scc_pkg::OP_NONE;
				ctrl.second = 1'b1;
			end
			scc_pkg::ST_P2_FETCH: begin
				ctrl.op = scc_pkg::OP_FETCH;
				ctrl.second = 1'b1;
			end
			scc_pkg::ST_P2_STEP: begin
				ctrl.op = scc_pkg::OP_STEP;
				ctrl.second = 1'b1;
			end
			scc_pkg::ST_P2_POP: begin
				ctrl.op = scc_pkg::OP_POP;
				ctrl.second = 1'b1;
			end
			default: ctrl.op = scc_pkg::OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

### sv/scc_datapath.sv
`default_nettype none
module scc_datapath #(
	parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [scc_pkg::CW-1:0] cfg_data,
	input wire scc_pkg::req_item_t req_item,
	input wire scc_pkg::ctrl_t ctrl,
	output scc_pkg::stat_t stat,
	input wire logic res_stall,
	output logic res_valid,
	output scc_pkg::res_item_t res_item
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT = AW + 1;
	localparam int VW = scc_pkg::VW;
	localparam int TW = scc_pkg::TW;

	logic [scc_pkg::CW-1:0] vcount_q;
	logic [CNT-1:0] n_eff;
	logic [MAX_VERTICES-1:0] nmask, visited_q, row_ok_q, col_ok_q;
	logic [MAX_VERTICES-1:0] adj_rd, adjt_rd, adj_wd, adjt_wd, edges, cand;
	logic rok_s1, cok_s1;
	logic cand_any;
	logic [AW-1:0] cand_idx;
	logic [VW-1:0] cur_q, root_q, s_q, d_q;
	logic pos_q;
	logic [AW-1:0] sp_q, k_q;
	logic [CNT-1:0] x_q, fin_idx_q, emit_q;
	logic [TW-1:0] time_q;
	logic out_valid_q;
	scc_pkg::res_item_t res_q;

	logic adj_re, adj_we;
	logic [AW-1:0] adj_raddr, adjt_raddr;
	logic stk_we, stk_re;
	logic [VW-1:0] stk_rd;
	logic fin_we, fin_re;
	logic [AW-1:0] fin_raddr;
	logic [TW-1:0] fin_rd;
	logic ord_re;
	logic [VW-1:0] ord_rd;
	logic is_step, sel_visited, last_emit, out_free;

	// Vertices in use, capped at the graph size.
	always_comb begin
		if (vcount_q > scc_pkg::CW'(MAX_VERTICES)) begin
			n_eff = CNT'(MAX_VERTICES);
		end else begin
			n_eff = vcount_q[CNT-1:0];
		end
		for (int i = 0; i < MAX_VERTICES; i++) begin
			nmask[i] = (CNT'(i) < n_eff);
		end
	end

	// Unvisited neighbors of the current vertex and the lowest one.
	always_comb begin
		if (ctrl.second) begin
			edges = cok_s1 ? adjt_rd : '0;
		end else begin
			edges = rok_s1 ? adj_rd : '0;
		end
		cand = edges & ~visited_q & nmask;
		cand_any = |cand;
		cand_idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				cand_idx = AW'(i);
			end
		end
	end

	assign is_step = (ctrl.op == scc_pkg::OP_STEP);
	assign sel_visited = visited_q[ord_rd[AW-1:0]];
	assign last_emit = (emit_q == n_eff - CNT'(1));
	assign out_free = !out_valid_q || !res_stall;

	// Memory port controls.
	always_comb begin
		adj_re = (ctrl.op == scc_pkg::OP_ADD_RD) || (ctrl.op == scc_pkg::OP_FETCH);
		adj_we = (ctrl.op == scc_pkg::OP_ADD_WR);
		if (ctrl.op == scc_pkg::OP_ADD_RD) begin
			adj_raddr = req_item.src_vertex[AW-1:0];
			adjt_raddr = req_item.dst_vertex[AW-1:0];
		end else begin
			adj_raddr = cur_q[AW-1:0];
			adjt_raddr = cur_q[AW-1:0];
		end
		adj_wd = rok_s1 ? adj_rd : '0;
		adj_wd[d_q[AW-1:0]] = pos_q;
		adjt_wd = cok_s1 ? adjt_rd : '0;
		adjt_wd[s_q[AW-1:0]] = pos_q;
		stk_we = is_step && cand_any;
		stk_re = is_step && !cand_any && (sp_q != '0);
		fin_we = is_step && !ctrl.second && !cand_any;
		fin_re = (is_step && ctrl.second && cand_any) ||
			((ctrl.op == scc_pkg::OP_SEL) && !sel_visited);
		fin_raddr = (ctrl.op == scc_pkg::OP_SEL) ? ord_rd[AW-1:0] : cand_idx;
		ord_re = (ctrl.op == scc_pkg::OP_ORD_RD);
	end

	// Adjacency rows and the transposed rows.
	scc_ram #(.W(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
		.clk(clk), .we(adj_we), .waddr(s_q[AW-1:0]), .wdata(adj_wd),
		.re(adj_re), .raddr(adj_raddr), .rdata(adj_rd)
	);
	scc_ram #(.W(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adjt (
		.clk(clk), .we(adj_we), .waddr(d_q[AW-1:0]), .wdata(adjt_wd),
		.re(adj_re), .raddr(adjt_raddr), .rdata(adjt_rd)
	);

	// Walk stack of vertices below the current one.
	scc_ram #(.W(VW), .DEPTH(MAX_VERTICES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(sp_q), .wdata(cur_q),
		.re(stk_re), .raddr(sp_q - AW'(1)), .rdata(stk_rd)
	);

	// First-pass finish time per vertex.
	scc_ram #(.W(TW), .DEPTH(MAX_VERTICES)) u_finish (
		.clk(clk), .we(fin_we), .waddr(cur_q[AW-1:0]), .wdata(time_q + TW'(1)),
		.re(fin_re), .raddr(fin_raddr), .rdata(fin_rd)
	);

	// Vertices in order of finishing.
	scc_ram #(.W(VW), .DEPTH(MAX_VERTICES)) u_order (
		.clk(clk), .we(fin_we), .waddr(fin_idx_q[AW-1:0]), .wdata(cur_q),
		.re(ord_re), .raddr(k_q), .rdata(ord_rd)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= scc_pkg::VCOUNT_RESET;
			visited_q <= '0;
			row_ok_q <= '0;
			col_ok_q <= '0;
			sp_q <= '0;
			k_q <= '0;
			x_q <= '0;
			fin_idx_q <= '0;
			emit_q <= '0;
			time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_data;
			end
			if (ctrl.op == scc_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.op)
				scc_pkg::OP_CLEAR: begin
					row_ok_q <= '0;
					col_ok_q <= '0;
				end
				scc_pkg::OP_ADD_WR: begin
					row_ok_q[s_q[AW-1:0]] <= 1'b1;
					col_ok_q[d_q[AW-1:0]] <= 1'b1;
				end
				scc_pkg::OP_RUN_INIT: begin
					visited_q <= '0;
					time_q <= '0;
					x_q <= '0;
					fin_idx_q <= '0;
				end
				scc_pkg::OP_P1_SCAN: begin
					if (x_q == n_eff) begin
						visited_q <= '0;
						k_q <= AW'(n_eff - CNT'(1));
						emit_q <= '0;
					end else begin
						x_q <= x_q + CNT'(1);
						if (!visited_q[x_q[AW-1:0]]) begin
							visited_q[x_q[AW-1:0]] <= 1'b1;
							time_q <= time_q + TW'(1);
							sp_q <= '0;
						end
					end
				end
				scc_pkg::OP_STEP: begin
					time_q <= time_q + TW'(1);
					if (cand_any) begin
						visited_q[cand_idx] <= 1'b1;
						sp_q <= sp_q + AW'(1);
					end else begin
						if (!ctrl.second) begin
							fin_idx_q <= fin_idx_q + CNT'(1);
						end
						if (sp_q != '0) begin
							sp_q <= sp_q - AW'(1);
						end
					end
				end
				scc_pkg::OP_SEL: begin
					if (sel_visited) begin
						k_q <= k_q - AW'(1);
					end else begin
						visited_q[ord_rd[AW-1:0]] <= 1'b1;
						sp_q <= '0;
					end
				end
				scc_pkg::OP_EMIT: emit_q <= emit_q + CNT'(1);
				default: ;
			endcase
		end
	end

	// Payload registers: edge being added, current vertex, tree root, result.
	always_ff @(posedge clk) begin
		if (adj_re) begin
			rok_s1 <= row_ok_q[adj_raddr];
			cok_s1 <= col_ok_q[adjt_raddr];
		end
		if (ctrl.op == scc_pkg::OP_ADD_RD) begin
			s_q <= req_item.src_vertex;
			d_q <= req_item.dst_vertex;
			pos_q <= (req_item.edge_weight > 16'sd0);
		end
		if (ctrl.op == scc_pkg::OP_P1_SCAN && x_q != n_eff) begin
			cur_q <= VW'(x_q[AW-1:0]);
		end
		if (is_step && cand_any) begin
			cur_q <= VW'(cand_idx);
		end
		if (ctrl.op == scc_pkg::OP_POP) begin
			cur_q <= stk_rd;
		end
		if (ctrl.op == scc_pkg::OP_SEL && !sel_visited) begin
			cur_q <= ord_rd;
			root_q <= ord_rd;
		end
		if (ctrl.op == scc_pkg::OP_EMIT) begin
			res_q.vertex <= cur_q;
			res_q.root <= root_q;
			res_q.finish_time <= fin_rd;
			res_q.last <= last_emit;
		end
	end

	// Status back to the controller.
	always_comb begin
		stat.n_zero = (n_eff == '0);
		stat.add_ok = (req_item.src_vertex < VW'(MAX_VERTICES)) &&
			(req_item.dst_vertex < VW'(MAX_VERTICES)) ||
			((MAX_VERTICES == (1 << VW)));
		stat.scan_done = (x_q == n_eff);
		stat.scan_hit = !visited_q[x_q[AW-1:0]];
		stat.cand_any = cand_any;
		stat.stack_empty = (sp_q == '0);
		stat.sel_visited = sel_visited;
		stat.out_free = out_free;
		stat.last_emit = last_emit;
	end

	assign res_valid = out_valid_q;
	assign res_item = res_q;

endmodule
`default_nettype wire

### sv/strongly_connected_components_core.sv
// Channel   Direction  Payload                 Handshake
// req       in         scc_pkg::req_item_t     req_valid / req_stall
// res       out        scc_pkg::res_item_t     res_valid / res_stall
// cfg       in         vertex_count (7 bits)   cfg_we
//
// An edge add reads, then writes, a row and a column.
// A run discovers each vertex with a row fetch and a step, and returns with a fetch,
// a step and, while the stack is not empty, a stack pop; pass one also scans the
// vertices in order, and pass two adds a finish-order read and one emit per vertex.
// Reset clears the graph through per-row valid bits; no clearing pass is needed.
// The walk waits while a result is stalled; requests are stalled during a run.
`default_nettype none
module strongly_connected_components_core #(
	parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [scc_pkg::CW-1:0] cfg_data,
	input wire logic req_valid,
	output logic req_stall,
	input wire scc_pkg::req_item_t req_item,
	output logic res_valid,
	input wire logic res_stall,
	output scc_pkg::res_item_t res_item
);

	scc_pkg::ctrl_t ctrl;
	scc_pkg::stat_t stat;

	// Sequencer for the two depth-first passes.
	scc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_cmd(req_item.cmd),
		.stat(stat),
		.req_stall(req_stall),
		.ctrl(ctrl)
	);

	// Graph storage, walk stack and result register.
	scc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_item(req_item),
		.ctrl(ctrl),
		.stat(stat),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res_item(res_item)
	);

endmodule
`default_nettype wire

### sv/scc_checker.sv
`default_nettype none
module scc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_stall,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire scc_pkg::res_item_t res_item
);

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	// Every reported finish time is nonzero.
	a_finish_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.finish_time != 8'd0)
		else $error("zero finish time");

	// Requests are held off until the last result of a run is out.
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.last |-> req_stall)
		else $error("request taken during a run");

endmodule

bind strongly_connected_components_core scc_checker u_scc_checker (.*);
`default_nettype wire

### test/scc_component_checker.sv
`timescale 1ns / 1ps
module scc_component_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [scc_pkg::CW-1:0] cfg_data,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire scc_pkg::req_item_t req_item,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire scc_pkg::res_item_t res_item,
	output int errors,
	output int pending
);

	// Shadow copy of the graph and the vertex count register.
	logic [63:0] edges [64];
	logic [7:0] finish_at [64];
	logic seen [64];
	logic unclaimed [64];
	logic [5:0] path_vertex [64];
	int path_next [64];
	int path_depth;
	int clock_ticks;
	int unclaimed_count;
	logic [5:0] tree_root;
	logic [scc_pkg::CW-1:0] vertex_limit;
	scc_pkg::res_item_t component_q [$];
	scc_pkg::res_item_t run_order [$];

	// Discovery of one vertex during either pass.
	task automatic discover_vertex(input int u, input bit transposed);
		scc_pkg::res_item_t r;
		seen[u] = 1'b1;
		clock_ticks++;
		if (transposed) begin
			unclaimed[u] = 1'b0;
			unclaimed_count--;
			r.vertex = u[5:0];
			r.root = tree_root;
			r.finish_time = finish_at[u];
			r.last = 1'b0;
			run_order.push_back(r);
		end
		path_vertex[path_depth] = u[5:0];
		path_next[path_depth] = 0;
		path_depth++;
	endtask

	// Depth-first tree from one start vertex, over the graph or its transpose.
	task automatic walk_tree(input int start, input int n, input bit transposed);
		int u;
		int v;
		path_depth = 0;
		discover_vertex(start, transposed);
		while (path_depth > 0) begin
			u = path_vertex[path_depth-1];
			v = path_next[path_depth-1];
			while (v < n && !(transposed ? edges[v][u] : edges[u][v]))
				v++;
			if (v < n) begin
				path_next[path_depth-1] = v + 1;
				if (!seen[v])
					discover_vertex(v, transposed);
			end else begin
				clock_ticks++;
				if (!transposed)
					finish_at[u] = clock_ticks[7:0];
				path_depth--;
			end
		end
	endtask

	// Full component search; queues one result per vertex in discovery order.
	task automatic predict_components();
		int n;
		int best;
		scc_pkg::res_item_t r;
		n = (vertex_limit > 64) ? 64 : int'(vertex_limit);
		run_order.delete();
		if (n == 0)
			return;
		clock_ticks = 0;
		for (int x = 0; x < 64; x++)
			seen[x] = 1'b0;
		for (int x = 0; x < n; x++)
			if (!seen[x])
				walk_tree(x, n, 1'b0);
		clock_ticks = 0;
		for (int x = 0; x < n; x++) begin
			seen[x] = 1'b0;
			unclaimed[x] = 1'b1;
		end
		unclaimed_count = n;
		while (unclaimed_count > 0) begin
			best = -1;
			for (int x = 0; x < n; x++)
				if (unclaimed[x] && (best < 0 || finish_at[x] > finish_at[best]))
					best = x;
			tree_root = best[5:0];
			walk_tree(best, n, 1'b1);
		end
		run_order[run_order.size()-1].last = 1'b1;
		while (run_order.size() > 0) begin
			r = run_order.pop_front();
			component_q.push_back(r);
		end
	endtask

	// Watch both channels and the register port at every clock edge.
	always @(posedge clk or negedge arst_n) begin
		scc_pkg::res_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++)
				edges[i] = '0;
			vertex_limit = scc_pkg::VCOUNT_RESET;
			component_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				vertex_limit = cfg_data;
			if (req_valid && !req_stall) begin
				case (req_item.cmd)
					scc_pkg::CMD_CLEAR: begin
						for (int i = 0; i < 64; i++)
							edges[i] = '0;
					end
					scc_pkg::CMD_ADD: begin
						edges[req_item.src_vertex][req_item.dst_vertex] =
							(req_item.edge_weight > 0);
					end
					scc_pkg::CMD_RUN: predict_components();
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (component_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: vertex %0d root %0d finish %0d last %0d",
							res_item.vertex, res_item.root, res_item.finish_time,
							res_item.last);
					errors++;
				end else begin
					want = component_q.pop_front();
					if (want != res_item) begin
						if (errors < 10)
							$display({"mismatch: expected v%0d r%0d f%0d l%0d,",
								" got v%0d r%0d f%0d l%0d"},
								want.vertex, want.root, want.finish_time, want.last,
								res_item.vertex, res_item.root, res_item.finish_time,
								res_item.last);
						errors++;
					end
				end
			end
			pending = component_q.size();
		end
	end
endmodule

### test/strongly_connected_components_core_test.sv
`timescale 1ns / 1ps
module strongly_connected_components_core_test;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [scc_pkg::CW-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	scc_pkg::req_item_t req_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	scc_pkg::res_item_t res_item;
	int errors;
	int pending;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int active_count = 64;

	// Clock and timeout.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	strongly_connected_components_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	scc_component_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.errors(errors),
		.pending(pending)
	);

	// Result side: random stall, or a long counted hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			res_stall <= 1'b1;
			hold_off--;
		end else begin
			res_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Offer one request and return at the edge that accepts it.
	task automatic send_request(input scc_pkg::req_item_t item);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= item;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic scc_pkg::req_item_t make_request(input logic [1:0] cmd, input int s,
			input int d, input int w);
		scc_pkg::req_item_t r;
		r.cmd = cmd;
		r.src_vertex = s[5:0];
		r.dst_vertex = d[5:0];
		r.edge_weight = w[15:0];
		return r;
	endfunction

	// Random request biased toward edges among the vertices in use.
	function automatic scc_pkg::req_item_t random_request();
		int pick;
		int top;
		scc_pkg::req_item_t r;
		pick = $urandom_range(99);
		top = (active_count < 1) ? 1 : ((active_count > 64) ? 64 : active_count);
		r = make_request(scc_pkg::CMD_ADD, $urandom_range(top - 1), $urandom_range(top - 1),
			$urandom);
		if ($urandom_range(9) == 0) begin
			r.src_vertex = $urandom;
			r.dst_vertex = $urandom;
		end
		if (pick < 9)
			r.cmd = scc_pkg::CMD_RUN;
		else if (pick < 12)
			r.cmd = scc_pkg::CMD_CLEAR;
		else if (pick < 14)
			r.cmd = scc_pkg::CMD_UNUSED;
		return r;
	endfunction

	// Stop offering, wait for every expected result, then let the block settle.
	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input int value);
		cfg_we <= 1'b1;
		cfg_data <= value[scc_pkg::CW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = value & 127;
	endtask

	initial begin
		int counts [8];
		counts = '{8, 1, 64, 3, 0, 127, 16, 2};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset count of 64.
		send_request(make_request(scc_pkg::CMD_RUN, 0, 0, 0));
		send_request(make_request(scc_pkg::CMD_ADD, 0, 63, 32767));
		send_request(make_request(scc_pkg::CMD_ADD, 63, 0, 1));
		send_request(make_request(scc_pkg::CMD_ADD, 5, 5, 1));
		send_request(make_request(scc_pkg::CMD_ADD, 1, 2, -32768));
		send_request(make_request(scc_pkg::CMD_ADD, 2, 1, 100));
		send_request(make_request(scc_pkg::CMD_ADD, 1, 2, 7));
		send_request(make_request(scc_pkg::CMD_ADD, 1, 2, 0));
		send_request(make_request(scc_pkg::CMD_ADD, 3, 4, -1));
		send_request(make_request(scc_pkg::CMD_ADD, 42, 21, 16'h5555));
		send_request(make_request(scc_pkg::CMD_ADD, 21, 42, 16'h2aaa));
		send_request(make_request(scc_pkg::CMD_UNUSED, 63, 63, -1));
		send_request(make_request(scc_pkg::CMD_RUN, 0, 0, 0));
		send_request(make_request(scc_pkg::CMD_CLEAR, 0, 0, 0));
		send_request(make_request(scc_pkg::CMD_RUN, 63, 63, 32767));
		drain();

		// Edges beyond a small count are kept but ignored by the run.
		write_count(4);
		send_request(make_request(scc_pkg::CMD_ADD, 0, 1, 3));
		send_request(make_request(scc_pkg::CMD_ADD, 1, 0, 3));
		send_request(make_request(scc_pkg::CMD_ADD, 2, 10, 3));
		send_request(make_request(scc_pkg::CMD_ADD, 3, 2, 3));
		send_request(make_request(scc_pkg::CMD_RUN, 0, 0, 0));
		drain();

		// Random phases over several counts and idle patterns.
		for (int p = 0; p < 8; p++) begin
			write_count(counts[p]);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			if (p == 6) begin
				// Long result hold-off while requests keep coming behind a run.
				send_request(make_request(scc_pkg::CMD_RUN, 0, 0, 0));
				hold_off = 400;
				for (int k = 0; k < 6; k++)
					send_request(random_request());
			end
			for (int k = 0; k < 36; k++)
				send_request(random_request());
			send_request(make_request(scc_pkg::CMD_RUN, 0, 0, 0));
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
